// File: sv/pei_pkg.sv
package pei_pkg;

  // Longest packet that the byte counter and the flip index cover
  localparam int MAX_PACKET = 2048;
  localparam int POS_W      = $clog2(MAX_PACKET + 1);

  // drand48 generator constants
  localparam int          LCG_W     = 48;
  localparam int          MUL_A_W   = 35;
  localparam int          ACC_W     = 64;
  localparam int          CHUNK_W   = 16;
  localparam int          PROD_W    = MUL_A_W + CHUNK_W;
  localparam logic [MUL_A_W-1:0] LCG_MUL   = 35'h5_DEEC_E66D;
  localparam logic [ACC_W-1:0]   LCG_ADD   = 64'hB;
  localparam logic [15:0]        SEED_LOW  = 16'h330E;
  localparam logic [LCG_W-1:0]   LCG_RESET = 48'h0000_000A_330E;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_EN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 2'd3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [11:0] packet_length;
    logic        last_byte;
  } pei_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       was_flipped;
  } pei_out_t;

  // Request to the shared multiply-accumulate unit
  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] opa;
    logic [LCG_W-1:0]   opb;
    logic [ACC_W-1:0]   init;
  } pei_mul_req_t;

  // Response: done pulses for one cycle while acc holds the result
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ACC_W-1:0] acc;
  } pei_mul_rsp_t;

endpackage

// File: sv/pei_mulacc.sv
module pei_mulacc import pei_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  pei_mul_req_t req,
  output pei_mul_rsp_t rsp
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [1:0]         step_r, step_nxt;
  logic [MUL_A_W-1:0] a_r, a_nxt;
  logic [LCG_W-1:0]   b_r, b_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [CHUNK_W-1:0] chunk;
  logic [ACC_W-1:0]   addend;

  // Pick the 16-bit slice of the second operand for this step
  always_comb begin
    case (step_r)
      2'd0:    chunk = b_r[15:0];
      2'd1:    chunk = b_r[31:16];
      2'd2:    chunk = b_r[47:32];
      default: chunk = '0;
    endcase
  end

  // Align the previous step's partial product
  always_comb begin
    case (step_r)
      2'd1:    addend = ACC_W'(prod_r);
      2'd2:    addend = ACC_W'({prod_r, 16'h0});
      2'd3:    addend = ACC_W'({prod_r, 32'h0});
      default: addend = '0;
    endcase
  end

  // Multiply one slice per cycle, accumulate the one before
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      a_nxt    = req.opa;
      b_nxt    = req.opb;
      acc_nxt  = req.init;
    end else if (busy_r) begin
      prod_nxt = a_r * chunk;
      acc_nxt  = acc_r + addend;
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.acc  = acc_r;

endmodule

// File: sv/packet_error_injector.sv
// Continuing bytes: accepted in idle, result registered by the emit step (waits on out_stall).
// First byte of a packet: one draw, a second one when drop and flip are both enabled,
//   then a draw and index scaling if a flip is armed, each on the shared 35x16 multiply unit.
// Dropped packets produce no output items and their emit step does not wait on out_stall.
// Reset (synchronous, rst_n low): generator loads 0xA330E (seed 10), threshold and
//   enables clear, byte counter restarts at packet start, output empties.
module packet_error_injector import pei_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pei_in_t              in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pei_out_t             out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DRAW  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_FLIP  = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [LCG_W-1:0] lcg_r, lcg_nxt;
  logic [LCG_W-1:0] thr_r, thr_nxt;
  logic             den_r, den_nxt;
  logic             fen_r, fen_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] len_r, len_nxt;
  logic [POS_W-1:0] fidx_r, fidx_nxt;
  logic             drop_r, drop_nxt;
  logic             armed_r, armed_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  pei_out_t         out_item_r, out_item_nxt;

  pei_mul_req_t     mul_req;
  pei_mul_rsp_t     mul_rsp;
  logic [LCG_W-1:0] res48;
  logic             hit;
  logic             hit_now;
  logic             out_free;
  logic [POS_W-1:0] len_clamped;

  pei_mulacc u_mulacc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign res48       = mul_rsp.acc[LCG_W-1:0];
  assign hit         = (res48 <= thr_r) && (den_r || fen_r);
  assign hit_now     = armed_r && (pos_r == fidx_r);
  assign out_free    = !out_valid_r || !out_stall;
  assign len_clamped = (int'(in_item.packet_length) > MAX_PACKET) ?
                       POS_W'(MAX_PACKET) : POS_W'(in_item.packet_length);

  // Sequence draws through the shared unit, then emit or drop the item
  always_comb begin
    state_nxt     = state_r;
    lcg_nxt       = lcg_r;
    thr_nxt       = thr_r;
    den_nxt       = den_r;
    fen_nxt       = fen_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    fidx_nxt      = fidx_r;
    drop_nxt      = drop_r;
    armed_nxt     = armed_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    mul_req.start = 1'b0;
    mul_req.opa   = LCG_MUL;
    mul_req.opb   = res48;
    mul_req.init  = LCG_ADD;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          data_nxt = in_item.data_byte;
          last_nxt = in_item.last_byte;
          if (pos_r == '0) begin
            len_nxt       = len_clamped;
            drop_nxt      = 1'b0;
            armed_nxt     = 1'b0;
            fidx_nxt      = '0;
            mul_req.start = 1'b1;
            mul_req.opb   = lcg_r;
            state_nxt     = S_DRAW;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_DRAW: begin
        if (mul_rsp.done) begin
          lcg_nxt = res48;
          if (hit && den_r && fen_r) begin
            mul_req.start = 1'b1;
            state_nxt     = S_PICK;
          end else if (hit && den_r) begin
            drop_nxt  = 1'b1;
            state_nxt = S_EMIT;
          end else if (hit) begin
            mul_req.start = 1'b1;
            state_nxt     = S_FLIP;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_PICK: begin
        if (mul_rsp.done) begin
          lcg_nxt = res48;
          if (res48[LCG_W-1]) begin
            mul_req.start = 1'b1;
            state_nxt     = S_FLIP;
          end else begin
            drop_nxt  = 1'b1;
            state_nxt = S_EMIT;
          end
        end
      end
      S_FLIP: begin
        // Scale the fresh draw by the packet length
        if (mul_rsp.done) begin
          lcg_nxt       = res48;
          mul_req.start = 1'b1;
          mul_req.opa   = MUL_A_W'(len_r);
          mul_req.init  = '0;
          state_nxt     = S_SCALE;
        end
      end
      S_SCALE: begin
        if (mul_rsp.done) begin
          fidx_nxt  = mul_rsp.acc[LCG_W +: POS_W];
          armed_nxt = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (drop_r || out_free) begin
          if (!drop_r) begin
            out_valid_nxt            = 1'b1;
            out_item_nxt.out_byte    = hit_now ? ~data_r : data_r;
            out_item_nxt.out_last    = last_r;
            out_item_nxt.was_flipped = hit_now;
          end
          // Advance the byte counter, restart at packet end
          if (last_r) begin
            pos_nxt   = '0;
            drop_nxt  = 1'b0;
            armed_nxt = 1'b0;
            fidx_nxt  = '0;
          end else if (int'(pos_r) < MAX_PACKET) begin
            pos_nxt = pos_r + POS_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Register writes; a seed write reloads the generator at once
    if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_nxt = cfg_data[LCG_W-1:0];
        CFG_DROP_EN:   den_nxt = cfg_data[0];
        CFG_FLIP_EN:   fen_nxt = cfg_data[0];
        CFG_SEED:      lcg_nxt = {cfg_data[31:0], SEED_LOW};
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lcg_r       <= LCG_RESET;
      thr_r       <= '0;
      den_r       <= 1'b0;
      fen_r       <= 1'b0;
      pos_r       <= '0;
      fidx_r      <= '0;
      drop_r      <= 1'b0;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lcg_r       <= lcg_nxt;
      thr_r       <= thr_nxt;
      den_r       <= den_nxt;
      fen_r       <= fen_nxt;
      pos_r       <= pos_nxt;
      fidx_r      <= fidx_nxt;
      drop_r      <= drop_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r      <= len_nxt;
    data_r     <= data_nxt;
    last_r     <= last_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The multiply unit only answers while a draw or scaling is pending
  a_done_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == S_DRAW || state_r == S_PICK ||
                      state_r == S_FLIP || state_r == S_SCALE))
    else $error("multiply result outside a draw");

  // The multiply unit is only started while it is idle
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiply started while busy");

  // A new output item only comes from the emit step
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("output raised outside emit");

  // The scaled flip index lies inside the packet
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> (fidx_r < len_r || len_r == '0))
    else $error("flip index beyond packet length");

  // A packet is never both dropped and flipped
  a_drop_xor_flip: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> !armed_r)
    else $error("drop and flip both set");

endmodule
